### sv/ic2d_pkg.sv
package ic2d_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_COEF  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_DRAIN = 2'd2
    } kind_t;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 24;
    localparam int SUM_W      = 32;
    localparam int POS_W      = 10;
    localparam int CFG_W      = 11;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register select is the word address bit of paddr
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd480;

    typedef struct packed {
        logic load;    // capture a stream push and read the line memories
        logic retire;  // write the line memories and shift the window
    } win_ctrl_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             last;
    } out_meta_t;

endpackage

### sv/ic2d_window.sv
module ic2d_window import ic2d_pkg::*; #(
    parameter int KERNEL_HEIGHT = 3,
    parameter int KERNEL_WIDTH  = 3,
    parameter int MAX_WIDTH     = 1024
) (
    input  logic                                               clk,
    input  win_ctrl_t                                          ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]                       rd_addr,
    input  logic [PIX_W-1:0]                                   pixel,
    output logic [KERNEL_HEIGHT-1:0][KERNEL_WIDTH-1:0][PIX_W-1:0] taps
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [PIX_W-1:0] pix_reg;
    logic [AW-1:0]    addr_reg;

    // Level k is the pixel stream delayed by k rows
    wire [PIX_W-1:0] lvl [KERNEL_HEIGHT];

    assign lvl[0] = pix_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pix_reg  <= pixel;
            addr_reg <= rd_addr;
        end
    end

    for (genvar g = 0; g < KERNEL_HEIGHT - 1; g++)
    begin : g_line
        logic [PIX_W-1:0] mem [MAX_WIDTH];
        logic [PIX_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (ctrl.retire)
            begin
                mem[addr_reg] <= lvl[g];
            end
            if (ctrl.load)
            begin
                // forward a same-column write (one pixel per row)
                if (ctrl.retire && rd_addr == addr_reg)
                begin
                    rd_reg <= lvl[g];
                end
                else
                begin
                    rd_reg <= mem[rd_addr];
                end
            end
        end

        assign lvl[g+1] = rd_reg;
    end

    for (genvar k = 0; k < KERNEL_HEIGHT; k++)
    begin : g_row
        assign taps[k][0] = lvl[k];

        if (KERNEL_WIDTH > 1)
        begin : g_shift
            logic [PIX_W-1:0] win_reg [KERNEL_WIDTH-1];

            always_ff @(posedge clk)
            begin
                if (ctrl.retire)
                begin
                    win_reg[0] <= lvl[k];
                    for (int j = 1; j < KERNEL_WIDTH - 1; j++)
                    begin
                        win_reg[j] <= win_reg[j-1];
                    end
                end
            end

            for (genvar j = 1; j < KERNEL_WIDTH; j++)
            begin : g_tap
                assign taps[k][j] = win_reg[j-1];
            end
        end
    end

endmodule

### sv/ic2d_mac.sv
module ic2d_mac import ic2d_pkg::*; #(
    parameter int KERNEL_HEIGHT = 3,
    parameter int KERNEL_WIDTH  = 3
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  tap_valid,
    output logic                                                  tap_stall,
    input  logic [KERNEL_HEIGHT-1:0][KERNEL_WIDTH-1:0][PIX_W-1:0] taps,
    input  logic [KERNEL_HEIGHT*KERNEL_WIDTH-1:0][COEF_W-1:0]     coefs,
    input  logic [KERNEL_HEIGHT-1:0]                              row_ok,
    input  logic [KERNEL_WIDTH-1:0]                               col_ok,
    input  out_meta_t                                             meta,
    output logic                                                  result_valid,
    input  logic                                                  result_stall,
    output logic [POS_W-1:0]                                      out_row,
    output logic [POS_W-1:0]                                      out_column,
    output logic signed [SUM_W-1:0]                               weighted_sum,
    output logic                                                  last_of_frame
);

    localparam int RS_W = PROD_W + $clog2(KERNEL_WIDTH + 1);

    logic vld_a_reg, vld_b_reg, vld_c_reg;
    logic rdy_a, rdy_b, rdy_c;

    logic signed [PROD_W-1:0] prod_next [KERNEL_HEIGHT][KERNEL_WIDTH];
    logic signed [PROD_W-1:0] prod_reg  [KERNEL_HEIGHT][KERNEL_WIDTH];
    logic signed [RS_W-1:0]   rsum_next [KERNEL_HEIGHT];
    logic signed [RS_W-1:0]   rsum_reg  [KERNEL_HEIGHT];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    out_meta_t                meta_a_reg, meta_b_reg, meta_c_reg;

    assign rdy_c     = !vld_c_reg || !result_stall;
    assign rdy_b     = !vld_b_reg || rdy_c;
    assign rdy_a     = !vld_a_reg || rdy_b;
    assign tap_stall = !rdy_a;

    // Tap (k, j) sits k rows and j pixels behind the newest pixel
    always_comb
    begin
        int kidx;
        for (int k = 0; k < KERNEL_HEIGHT; k++)
        begin
            for (int j = 0; j < KERNEL_WIDTH; j++)
            begin
                kidx = (KERNEL_HEIGHT - 1 - k) * KERNEL_WIDTH + (KERNEL_WIDTH - 1 - j);
                if (row_ok[KERNEL_HEIGHT-1-k] && col_ok[KERNEL_WIDTH-1-j])
                begin
                    prod_next[k][j] = PROD_W'(signed'(coefs[kidx]))
                                    * PROD_W'(signed'({1'b0, taps[k][j]}));
                end
                else
                begin
                    prod_next[k][j] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < KERNEL_HEIGHT; k++)
        begin
            rsum_next[k] = '0;
            for (int j = 0; j < KERNEL_WIDTH; j++)
            begin
                rsum_next[k] = rsum_next[k] + RS_W'(prod_reg[k][j]);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < KERNEL_HEIGHT; k++)
        begin
            sum_next = sum_next + SUM_W'(rsum_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                vld_a_reg <= tap_valid;
            end
            if (rdy_b)
            begin
                vld_b_reg <= vld_a_reg;
            end
            if (rdy_c)
            begin
                vld_c_reg <= vld_b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && tap_valid)
        begin
            prod_reg   <= prod_next;
            meta_a_reg <= meta;
        end
        if (rdy_b && vld_a_reg)
        begin
            rsum_reg   <= rsum_next;
            meta_b_reg <= meta_a_reg;
        end
        if (rdy_c && vld_b_reg)
        begin
            sum_reg    <= sum_next;
            meta_c_reg <= meta_b_reg;
        end
    end

    assign result_valid  = vld_c_reg;
    assign out_row       = meta_c_reg.row;
    assign out_column    = meta_c_reg.column;
    assign last_of_frame = meta_c_reg.last;
    assign weighted_sum  = sum_reg;

endmodule

### sv/image_convolution_2d_top.sv
// Same-size 2D convolution of a raster-order 8-bit frame with an odd
// KERNEL_HEIGHT x KERNEL_WIDTH kernel of Q1.14 coefficients, zero padded at
// the borders; weighted_sum is the exact Q.14 sum. One item is taken per
// clock while item_stall is low, and the result that it causes passes the
// input register, product stage, row-sum stage and output register. Each
// pixel emits the output that lags it by KERNEL_HEIGHT/2 rows plus
// KERNEL_WIDTH/2 pixels; drain items emit the rest after the frame. The
// window comes from KERNEL_HEIGHT-1 line memories of MAX_WIDTH bytes, read
// and written once per pixel at the current column. For a frame so small
// that it holds fewer pixels than that lag, the block pushes one fill step
// per missing pixel after the last pixel to advance the line memories,
// and holds the input stalled meanwhile. Writing either size register drops
// the frame in progress; the kernel is kept.
module image_convolution_2d_top import ic2d_pkg::*; #(
    parameter int KERNEL_HEIGHT = 3,
    parameter int KERNEL_WIDTH  = 3,
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // APB configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    // item channel
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               kind,
    input  logic [3:0]               coef_index,
    input  logic signed [COEF_W-1:0] coefficient,
    input  logic [PIX_W-1:0]         pixel,
    // result channel
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [POS_W-1:0]         out_row,
    output logic [POS_W-1:0]         out_column,
    output logic signed [SUM_W-1:0]  weighted_sum,
    output logic                     last_of_frame
);

    localparam int RAD_H = KERNEL_HEIGHT / 2;
    localparam int RAD_W = KERNEL_WIDTH / 2;
    localparam int TAPS  = KERNEL_HEIGHT * KERNEL_WIDTH;
    localparam int TIW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT);
    localparam int HCW   = $clog2(MAX_HEIGHT + 1);
    localparam int VMAX  = MAX_WIDTH * MAX_HEIGHT + RAD_H * MAX_WIDTH + RAD_W;
    localparam int VW    = $clog2(VMAX + 1);

    // configuration
    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic             cfg_wr;
    logic [CW-1:0]    w_eff;
    logic [HCW-1:0]   h_eff;
    logic [VW-1:0]    lag;

    // position counters
    logic [HCW-1:0] in_row_reg, in_row_next;
    logic [AW-1:0]  in_col_reg, in_col_next;
    logic [AW-1:0]  strm_col_reg, strm_col_next;
    logic [VW-1:0]  vcnt_reg, vcnt_next;
    logic [HW-1:0]  out_row_reg, out_row_next;
    logic [AW-1:0]  out_col_reg, out_col_next;

    // input stage decode
    logic in_done, out_pending, fill_need, fill_go;
    logic item_acc, pix_act, drn_act, coef_act;
    logic s0_push, s0_emit, s0_load, last0;
    logic [KERNEL_HEIGHT-1:0] row_ok0;
    logic [KERNEL_WIDTH-1:0]  col_ok0;
    out_meta_t                meta0;

    // window stage
    logic                     vld1_reg, push1_reg, emit1_reg, coef1_reg;
    logic [TIW-1:0]           cidx1_reg;
    logic [COEF_W-1:0]        cval1_reg;
    logic [KERNEL_HEIGHT-1:0] row_ok1_reg;
    logic [KERNEL_WIDTH-1:0]  col_ok1_reg;
    out_meta_t                meta1_reg;
    logic                     ready1, s1_adv;

    logic [TAPS-1:0][COEF_W-1:0]                           kernel_reg;
    logic [KERNEL_HEIGHT-1:0][KERNEL_WIDTH-1:0][PIX_W-1:0] taps;
    win_ctrl_t                                             win_ctrl;
    logic                                                  mac_stall;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_next  = pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp the sizes to 1..MAX
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (int'(frame_width_reg) > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_eff = HCW'(1);
        end
        else if (int'(frame_height_reg) > MAX_HEIGHT)
        begin
            h_eff = HCW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HCW'(frame_height_reg);
        end
    end

    assign lag         = VW'(w_eff) * VW'(RAD_H) + VW'(RAD_W);
    assign in_done     = in_row_reg >= h_eff;
    assign out_pending = HCW'(out_row_reg) < h_eff;
    // a tiny frame ends before the stream reaches the first output
    assign fill_need   = in_done && (vcnt_reg < lag);

    assign s1_adv     = vld1_reg && (!emit1_reg || !mac_stall);
    assign ready1     = !vld1_reg || s1_adv;
    assign item_stall = !ready1 || fill_need;
    assign item_acc   = item_valid && !item_stall;

    always_comb
    begin
        pix_act  = 1'b0;
        drn_act  = 1'b0;
        coef_act = 1'b0;
        case (kind_t'(kind))
            KIND_COEF:  coef_act = item_acc && (int'(coef_index) < TAPS);
            KIND_PIXEL: pix_act  = item_acc && !in_done;
            KIND_DRAIN: drn_act  = item_acc && in_done && out_pending;
            default:    ;
        endcase
    end

    assign fill_go = fill_need && ready1;
    assign s0_push = pix_act || drn_act || fill_go;
    assign s0_emit = (pix_act && (vcnt_reg >= lag)) || drn_act;
    assign s0_load = s0_push || coef_act;
    assign last0   = (HCW'(out_row_reg) == h_eff - HCW'(1))
                  && (CW'(out_col_reg) == w_eff - CW'(1));

    // mark the kernel rows and columns that land inside the frame
    always_comb
    begin
        for (int i = 0; i < KERNEL_HEIGHT; i++)
        begin
            row_ok0[i] = (int'(out_row_reg) + i - RAD_H >= 0)
                      && (int'(out_row_reg) + i - RAD_H < int'(h_eff));
        end
        for (int i = 0; i < KERNEL_WIDTH; i++)
        begin
            col_ok0[i] = (int'(out_col_reg) + i - RAD_W >= 0)
                      && (int'(out_col_reg) + i - RAD_W < int'(w_eff));
        end
    end

    assign meta0.row    = POS_W'(out_row_reg);
    assign meta0.column = POS_W'(out_col_reg);
    assign meta0.last   = last0;

    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        strm_col_next = strm_col_reg;
        vcnt_next     = vcnt_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;

        if (pix_act)
        begin
            if (CW'(in_col_reg) + CW'(1) == w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + HCW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end
        end

        // the stream keeps stepping through drains and fills
        if (s0_push)
        begin
            vcnt_next = vcnt_reg + VW'(1);
            if (CW'(strm_col_reg) + CW'(1) == w_eff)
            begin
                strm_col_next = '0;
            end
            else
            begin
                strm_col_next = strm_col_reg + AW'(1);
            end
        end

        if (s0_emit && !last0)
        begin
            if (CW'(out_col_reg) + CW'(1) == w_eff)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + HW'(1);
            end
            else
            begin
                out_col_next = out_col_reg + AW'(1);
            end
        end

        // end of frame or a size change restarts the frame
        if ((s0_emit && last0) || cfg_wr)
        begin
            in_row_next   = '0;
            in_col_next   = '0;
            strm_col_next = '0;
            vcnt_next     = '0;
            out_row_next  = '0;
            out_col_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
            in_row_reg       <= '0;
            in_col_reg       <= '0;
            strm_col_reg     <= '0;
            vcnt_reg         <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            vld1_reg         <= 1'b0;
            kernel_reg       <= '0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_row_reg       <= in_row_next;
            in_col_reg       <= in_col_next;
            strm_col_reg     <= strm_col_next;
            vcnt_reg         <= vcnt_next;
            out_row_reg      <= out_row_next;
            out_col_reg      <= out_col_next;
            if (ready1)
            begin
                vld1_reg <= s0_load;
            end
            // kernel changes in item order, behind any earlier product
            if (s1_adv && coef1_reg)
            begin
                kernel_reg[cidx1_reg] <= cval1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && s0_load)
        begin
            push1_reg   <= s0_push;
            emit1_reg   <= s0_emit;
            coef1_reg   <= coef_act;
            cidx1_reg   <= TIW'(coef_index);
            cval1_reg   <= coefficient;
            row_ok1_reg <= row_ok0;
            col_ok1_reg <= col_ok0;
            meta1_reg   <= meta0;
        end
    end

    assign win_ctrl.load   = s0_push;
    assign win_ctrl.retire = s1_adv && push1_reg;

    ic2d_window #(
        .KERNEL_HEIGHT (KERNEL_HEIGHT),
        .KERNEL_WIDTH  (KERNEL_WIDTH),
        .MAX_WIDTH     (MAX_WIDTH)
    ) u_window (
        .clk     (clk),
        .ctrl    (win_ctrl),
        .rd_addr (strm_col_reg),
        .pixel   (pixel),
        .taps    (taps)
    );

    ic2d_mac #(
        .KERNEL_HEIGHT (KERNEL_HEIGHT),
        .KERNEL_WIDTH  (KERNEL_WIDTH)
    ) u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .tap_valid     (vld1_reg && emit1_reg),
        .tap_stall     (mac_stall),
        .taps          (taps),
        .coefs         (kernel_reg),
        .row_ok        (row_ok1_reg),
        .col_ok        (col_ok1_reg),
        .meta          (meta1_reg),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .out_row       (out_row),
        .out_column    (out_column),
        .weighted_sum  (weighted_sum),
        .last_of_frame (last_of_frame)
    );

endmodule

### sv/ic2d_checker.sv
module ic2d_checker import ic2d_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     result_valid,
    input logic                     result_stall,
    input logic [POS_W-1:0]         out_row,
    input logic [POS_W-1:0]         out_column,
    input logic signed [SUM_W-1:0]  weighted_sum,
    input logic                     last_of_frame
);

    logic res_xfer;

    assign res_xfer = result_valid && !result_stall;

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid on the first cycle after reset");

    // a stalled result holds still
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(weighted_sum)
            && $stable(out_row) && $stable(out_column) && $stable(last_of_frame))
        else $error("stalled result changed");

    // a back-to-back transfer after the last one of a frame starts the next frame
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && last_of_frame ##1 res_xfer |-> out_row == '0 && out_column == '0)
        else $error("new frame does not start at the origin");

    // back-to-back transfers within a frame step in raster order
    a_raster_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && !last_of_frame ##1 res_xfer |->
            (out_column == POS_W'($past(out_column) + POS_W'(1))
                && out_row == $past(out_row))
            || (out_column == '0 && out_row == POS_W'($past(out_row) + POS_W'(1))))
        else $error("output position out of raster order");

endmodule

bind image_convolution_2d_top ic2d_checker u_ic2d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_row       (out_row),
    .out_column    (out_column),
    .weighted_sum  (weighted_sum),
    .last_of_frame (last_of_frame)
);

### tb/image_convolution_2d_top_test.sv
`timescale 1ns / 100ps

module image_convolution_2d_top_test;
    import ic2d_pkg::*;

    localparam int KH             = 3;
    localparam int KW             = 3;
    localparam int MAX_W          = 1024;
    localparam int MAX_H          = 1024;
    localparam int TAPS           = KH * KW;
    localparam int LINE_SLOTS     = 2 * (KH / 2) * MAX_W + 2 * (KW / 2) + 1;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        column;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } conv_out_t;

    class conv_scoreboard;
        logic signed [COEF_W-1:0] taps [TAPS];
        logic [PIX_W-1:0]         line_pixels [LINE_SLOTS];
        logic [CFG_W-1:0]         width_raw;
        logic [CFG_W-1:0]         height_raw;
        int                       in_row;
        int                       in_col;
        int                       next_row;
        int                       next_col;
        conv_out_t                expected_outputs [$];
        int                       errors;

        function new();
            foreach (taps[i]) taps[i] = '0;
            foreach (line_pixels[i]) line_pixels[i] = '0;
            width_raw  = RESET_FRAME_WIDTH;
            height_raw = RESET_FRAME_HEIGHT;
            errors     = 0;
            rewind();
        endfunction

        function void rewind();
            in_row   = 0;
            in_col   = 0;
            next_row = 0;
            next_col = 0;
        endfunction

        function int eff_width();
            if (width_raw == 0) return 1;
            if (width_raw > MAX_W) return MAX_W;
            return int'(width_raw);
        endfunction

        function int eff_height();
            if (height_raw == 0) return 1;
            if (height_raw > MAX_H) return MAX_H;
            return int'(height_raw);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void write_size(logic sel, logic [CFG_W-1:0] value);
            if (sel == REG_FRAME_WIDTH)
                width_raw = value;
            else
                height_raw = value;
            rewind();
        endfunction

        // Sum the in-frame taps around the next output position, then advance it
        function conv_out_t convolve_next();
            int        w;
            int        h;
            int        rr;
            int        cc;
            longint    lin;
            longint    acc;
            conv_out_t o;
            w   = eff_width();
            h   = eff_height();
            acc = 0;
            for (int dr = -(KH / 2); dr <= KH / 2; dr++)
            begin
                rr = next_row + dr;
                if (rr < 0 || rr >= h) continue;
                for (int dc = -(KW / 2); dc <= KW / 2; dc++)
                begin
                    cc = next_col + dc;
                    if (cc < 0 || cc >= w) continue;
                    lin = longint'(rr) * w + cc;
                    acc += longint'(taps[(dr + KH / 2) * KW + dc + KW / 2])
                           * longint'(line_pixels[lin % LINE_SLOTS]);
                end
            end
            o.row    = next_row[POS_W-1:0];
            o.column = next_col[POS_W-1:0];
            o.sum    = acc[SUM_W-1:0];
            o.last   = (next_row == h - 1) && (next_col == w - 1);
            if (o.last)
                rewind();
            else
            begin
                next_col++;
                if (next_col >= w)
                begin
                    next_col = 0;
                    next_row++;
                end
            end
            return o;
        endfunction

        function void note_item(logic [1:0] k, logic [3:0] idx,
                                logic signed [COEF_W-1:0] cf, logic [PIX_W-1:0] px);
            int     w;
            int     h;
            longint lin;
            longint olin;
            longint lag;
            w   = eff_width();
            h   = eff_height();
            lag = longint'(KH / 2) * w + KW / 2;
            case (k)
                KIND_COEF:
                begin
                    if (idx < TAPS)
                        taps[idx] = cf;
                end
                KIND_PIXEL:
                begin
                    // drop pixels past the end of a frame still draining
                    if (in_row < h)
                    begin
                        lin = longint'(in_row) * w + in_col;
                        line_pixels[lin % LINE_SLOTS] = px;
                        in_col++;
                        if (in_col >= w)
                        begin
                            in_col = 0;
                            in_row++;
                        end
                        olin = longint'(next_row) * w + next_col;
                        if (next_row < h && olin + lag <= lin)
                            expected_outputs.insert(expected_outputs.size(), convolve_next());
                    end
                end
                KIND_DRAIN:
                begin
                    if (in_row >= h && next_row < h)
                        expected_outputs.insert(expected_outputs.size(), convolve_next());
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [POS_W-1:0] row, logic [POS_W-1:0] column,
                                   logic signed [SUM_W-1:0] sum, logic last);
            conv_out_t want;
            if (expected_outputs.size() == 0)
            begin
                flag($sformatf("unexpected output: row %0d col %0d sum %0d last %0b",
                               row, column, sum, last));
                return;
            end
            want = expected_outputs.pop_front();
            if (want.row !== row || want.column !== column || want.sum !== sum
                || want.last !== last)
                flag($sformatf({"output mismatch: expected row %0d col %0d sum %0d last %0b,",
                                " got row %0d col %0d sum %0d last %0b"},
                               want.row, want.column, want.sum, want.last,
                               row, column, sum, last));
        endfunction
    endclass

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr        = '0;
    logic [APB_DATA_W-1:0]   pwdata       = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    item_valid   = 1'b0;
    logic                    item_stall;
    logic [1:0]              kind         = '0;
    logic [3:0]              coef_index   = '0;
    logic signed [COEF_W-1:0] coefficient = '0;
    logic [PIX_W-1:0]        pixel        = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_column;
    logic signed [SUM_W-1:0] weighted_sum;
    logic                    last_of_frame;

    conv_scoreboard conv;
    bit             calm        = 1'b0;
    int             items_sent  = 0;
    int             stall_left  = 0;
    int             quiet_cycles = 0;

    image_convolution_2d_top #(
        .KERNEL_HEIGHT(KH),
        .KERNEL_WIDTH (KW),
        .MAX_WIDTH    (MAX_W),
        .MAX_HEIGHT   (MAX_H)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .coef_index   (coef_index),
        .coefficient  (coefficient),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_row      (out_row),
        .out_column   (out_column),
        .weighted_sum (weighted_sum),
        .last_of_frame(last_of_frame)
    );

    always #10 clk = ~clk;

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Result side: hold stall for a drawn number of cycles after each transfer
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            stall_left = draw_wait();
            result_stall <= (stall_left != 0);
        end
        else
        begin
            if (stall_left != 0)
                stall_left--;
            else if (!calm && $urandom_range(0, 15) == 0)
                stall_left = $urandom_range(1, 15);
            result_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                conv.check_result(out_row, out_column, weighted_sum, last_of_frame);
            if (item_valid && !item_stall)
                conv.note_item(kind, coef_index, coefficient, pixel);
            if ((result_valid && !result_stall) || (item_valid && !item_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] k, input logic [3:0] idx,
                             input logic [COEF_W-1:0] cf, input logic [PIX_W-1:0] px);
        int gap;
        bit hold_off;
        gap      = draw_wait();
        hold_off = ($urandom_range(0, 79) == 0);
        if (hold_off || gap != 0)
        begin
            item_valid <= 1'b0;
            // hold until every pending output has drained
            if (hold_off)
                do @(posedge clk); while (conv.expected_outputs.size() != 0);
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        kind        <= k;
        coef_index  <= idx;
        coefficient <= cf;
        pixel       <= px;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        // let the last transfer reach the scoreboard first
        @(posedge clk);
        while (conv.expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one size register, then read it back
    task automatic program_size(input logic sel, input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        word[CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        conv.write_size(sel, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[CFG_W-1:0] !== value)
            conv.flag($sformatf("register %0d readback: expected %0d, got %0d",
                                sel, value, prdata[CFG_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_frame(input bit tidy, input bit cut);
        int w;
        int h;
        int n;
        int lag;
        int drains;
        int sent;
        w      = conv.eff_width();
        h      = conv.eff_height();
        n      = w * h;
        lag    = (KH / 2) * w + KW / 2;
        drains = (n < lag) ? n : lag;
        sent   = cut ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < sent; i++)
        begin
            if (!tidy && $urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_item(KIND_COEF, 4'($urandom_range(0, 15)), COEF_W'($urandom),
                                 PIX_W'($urandom));
                    1: send_item(KIND_DRAIN, 4'($urandom), COEF_W'($urandom),
                                 PIX_W'($urandom));
                    default: send_item(KIND_UNUSED, 4'($urandom), COEF_W'($urandom),
                                       PIX_W'($urandom));
                endcase
            end
            send_item(KIND_PIXEL, 4'($urandom), COEF_W'($urandom),
                      ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                  : PIX_W'($urandom));
        end
        if (cut) return;
        // extra pixels while the frame drains
        if (!tidy && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                send_item(KIND_PIXEL, 4'($urandom), COEF_W'($urandom), PIX_W'($urandom));
        repeat (drains)
            send_item(KIND_DRAIN, 4'($urandom), COEF_W'($urandom), PIX_W'($urandom));
        if (!tidy)
            repeat ($urandom_range(0, 2))
                send_item(KIND_DRAIN, 4'($urandom), COEF_W'($urandom), PIX_W'($urandom));
    endtask

    initial
    begin
        int               phase;
        int               frames;
        bit               big;
        logic [CFG_W-1:0] w_set;
        logic [CFG_W-1:0] h_set;

        conv = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficient extremes, out-of-range indexes, unused kind, idle drain
        send_item(KIND_COEF, 4'd0, 16'h8000, PIX_W'($urandom));
        send_item(KIND_COEF, 4'd1, 16'h7FFF, PIX_W'($urandom));
        send_item(KIND_COEF, 4'd2, 16'h0000, PIX_W'($urandom));
        send_item(KIND_COEF, 4'd3, 16'h0001, PIX_W'($urandom));
        send_item(KIND_COEF, 4'd4, 16'hFFFF, PIX_W'($urandom));
        for (int i = 5; i < TAPS; i++)
            send_item(KIND_COEF, 4'(i), COEF_W'($urandom), PIX_W'($urandom));
        send_item(KIND_COEF, 4'd9, COEF_W'($urandom), PIX_W'($urandom));
        send_item(KIND_COEF, 4'd15, COEF_W'($urandom), PIX_W'($urandom));
        send_item(KIND_UNUSED, 4'($urandom), COEF_W'($urandom), PIX_W'($urandom));
        send_item(KIND_DRAIN, 4'($urandom), COEF_W'($urandom), PIX_W'($urandom));
        // partial frame at the reset size, abandoned by the writes below
        send_item(KIND_PIXEL, 4'($urandom), COEF_W'($urandom), 8'h00);
        send_item(KIND_PIXEL, 4'($urandom), COEF_W'($urandom), 8'hFF);

        wait_idle();
        program_size(REG_FRAME_WIDTH, 11'd0);
        program_size(REG_FRAME_HEIGHT, 11'd0);
        run_frame(1'b1, 1'b0);
        send_item(KIND_DRAIN, 4'($urandom), COEF_W'($urandom), PIX_W'($urandom));

        wait_idle();
        program_size(REG_FRAME_WIDTH, 11'd3);
        program_size(REG_FRAME_HEIGHT, 11'd2);
        run_frame(1'b0, 1'b0);

        phase = 0;
        while (items_sent < 950)
        begin
            wait_idle();
            calm = ($urandom_range(0, 4) == 0);
            big  = (phase == 2 || phase == 5);
            if (phase == 2)
            begin
                program_size(REG_FRAME_WIDTH, 11'd2047);
                program_size(REG_FRAME_HEIGHT, 11'd1);
            end
            else if (phase == 5)
            begin
                program_size(REG_FRAME_WIDTH, 11'd1);
                program_size(REG_FRAME_HEIGHT, 11'd2047);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: w_set = 11'd0;
                    1: w_set = 11'd1;
                    default: w_set = CFG_W'($urandom_range(2, 12));
                endcase
                case ($urandom_range(0, 9))
                    0: h_set = 11'd0;
                    1: h_set = 11'd1;
                    default: h_set = CFG_W'($urandom_range(2, 8));
                endcase
                if (conv.eff_width() > 12 || $urandom_range(0, 3) != 0)
                    program_size(REG_FRAME_WIDTH, w_set);
                program_size(REG_FRAME_HEIGHT, h_set);
            end
            repeat ($urandom_range(0, 4))
                send_item(KIND_COEF, 4'($urandom_range(0, TAPS)), COEF_W'($urandom),
                          PIX_W'($urandom));
            if (big)
            begin
                // part of a frame at a clamped size, dropped by the next size write
                repeat ($urandom_range(40, 120))
                    send_item(KIND_PIXEL, 4'($urandom), COEF_W'($urandom), PIX_W'($urandom));
            end
            else
            begin
                frames = $urandom_range(1, 3);
                for (int f = 0; f < frames; f++)
                    run_frame($urandom_range(0, 3) != 0,
                              f == frames - 1 && $urandom_range(0, 4) == 0);
            end
            phase++;
        end

        wait_idle();
        if (conv.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
